@@ rtl/core/gfce_pkg.sv @@
package gfce_pkg;

  localparam int SAMPLE_W = 8;
  localparam int PAIR_W = SAMPLE_W + 1;
  localparam int RADIUS_W = 3;
  localparam int SEEN_W = 3;
  localparam int COUNT_W = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int MAX_RADIUS_DEFAULT = 6;
  localparam int TAP_FRACTION_BITS_DEFAULT = 16;

  localparam logic [SEEN_W-1:0] SEEN_MAX = 3'd7;

  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_CENTER = 3'd1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic push;
    logic load;
  } cell_ctrl_t;

endpackage

@@ rtl/core/gfce_cell.sv @@
module gfce_cell (
  input  logic                clk,
  input  gfce_pkg::cell_ctrl_t ctrl,
  input  gfce_pkg::sample_t   fill_value,
  input  gfce_pkg::sample_t   shift_in,
  output gfce_pkg::sample_t   value
);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      value <= ctrl.load ? fill_value : shift_in;
    end
  end

endmodule

@@ rtl/core/gfce_tap.sv @@
module gfce_tap #(
  parameter int TAP_W = gfce_pkg::TAP_FRACTION_BITS_DEFAULT + 1,
  parameter int PROD_W = TAP_W + gfce_pkg::PAIR_W
) (
  input  logic              clk,
  input  logic              en,
  input  gfce_pkg::sample_t near,
  input  gfce_pkg::sample_t far,
  input  logic [TAP_W-1:0]  tap,
  output logic [PROD_W-1:0] product
);

  logic [gfce_pkg::PAIR_W-1:0] pair;

  always_ff @(posedge clk) begin
    if (en) begin
      pair <= {1'b0, near} + {1'b0, far};
      product <= PROD_W'(tap) * PROD_W'(pair);
    end
  end

endmodule

@@ rtl/core/gaussian_fir_clamped_edges.sv @@
// Symmetric FIR smoother for one line of 8-bit samples with the edge samples
// replicated past both ends of the line. Samples enter at one word per clock
// unless the output stalls or a flush runs, and shift through window cells,
// then the pair add, multiply, partial sum and output registers. A word with
// end_of_line set makes the block push the last sample again r_eff times (the
// radius clamped to 1..MAX_RADIUS) to flush the rest, holding off input; the
// final result of the line carries line_done. Taps are unsigned fixed point
// with TAP_FRACTION_BITS fraction bits; the sum is truncated and saturated at
// 255. Write the registers only while the block is idle.
module gaussian_fir_clamped_edges #(
  parameter int MAX_RADIUS = gfce_pkg::MAX_RADIUS_DEFAULT,
  parameter int TAP_FRACTION_BITS = gfce_pkg::TAP_FRACTION_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [gfce_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [TAP_FRACTION_BITS:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       sample,
  input  logic                             end_of_line,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       smoothed,
  output logic                             line_done
);

  localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int TAP_W = TAP_FRACTION_BITS + 1;
  localparam int PROD_W = TAP_W + gfce_pkg::PAIR_W;
  localparam int NPART = (MAX_RADIUS + 2) / 2;
  localparam int PART_W = PROD_W + 1;
  localparam int ACC_W = PROD_W + 3;
  localparam int SCALED_W = ACC_W - TAP_FRACTION_BITS;

  logic [gfce_pkg::RADIUS_W-1:0] radius;
  logic [TAP_W-1:0]              taps [0:MAX_RADIUS];
  logic [gfce_pkg::RADIUS_W-1:0] r_eff;

  logic [gfce_pkg::RADIUS_W-1:0] flush_left;
  logic [gfce_pkg::SEEN_W-1:0]   samples_seen;
  logic [gfce_pkg::COUNT_W-1:0]  cnt;
  logic [gfce_pkg::SEEN_W-1:0]   seen;
  logic [gfce_pkg::COUNT_W-1:0]  cnt_next;

  logic adv, flushing, accept, push, emit, last;
  logic v0, v1, v2, v3;
  logic l0, l1, l2, l3;

  gfce_pkg::cell_ctrl_t ctrl;
  gfce_pkg::sample_t    new_sample;
  gfce_pkg::sample_t    win [0:WIN_DEPTH-1];
  gfce_pkg::sample_t    near_s [0:MAX_RADIUS];
  gfce_pkg::sample_t    far_s [0:MAX_RADIUS];

  logic [PROD_W-1:0]   prod [0:MAX_RADIUS];
  logic [PART_W-1:0]   part [0:NPART-1];
  logic [ACC_W-1:0]    total;
  logic [SCALED_W-1:0] scaled;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= gfce_pkg::RADIUS_W'(1);
    end else if (cfg_write && cfg_index == gfce_pkg::REG_RADIUS) begin
      radius <= cfg_data[gfce_pkg::RADIUS_W-1:0];
    end
  end

  for (genvar d = 0; d <= MAX_RADIUS; d++) begin : g_tap_reg
    always_ff @(posedge clk) begin
      if (rst) begin
        taps[d] <= (d == 0) ? TAP_W'(1) << TAP_FRACTION_BITS : '0;
      end else if (cfg_write &&
                   cfg_index == gfce_pkg::REG_TAP_CENTER + gfce_pkg::CFG_INDEX_W'(d)) begin
        taps[d] <= cfg_data;
      end
    end
  end

  always_comb begin
    if (radius == '0) begin
      r_eff = gfce_pkg::RADIUS_W'(1);
    end else if (radius > gfce_pkg::RADIUS_W'(MAX_RADIUS)) begin
      r_eff = gfce_pkg::RADIUS_W'(MAX_RADIUS);
    end else begin
      r_eff = radius;
    end
  end

  // Line control and flush sequencing.
  assign adv = !out_valid || out_ready;
  assign flushing = flush_left != '0;
  assign in_ready = adv && !flushing;
  assign accept = in_valid && in_ready;
  assign push = accept || (adv && flushing);
  assign seen = (samples_seen == gfce_pkg::SEEN_MAX) ? gfce_pkg::SEEN_MAX
                                                     : samples_seen + 1'b1;
  assign cnt_next = cnt + 1'b1;
  assign emit = flushing ? (cnt_next > {1'b0, r_eff}) : (seen > r_eff);
  assign last = flushing && flush_left == gfce_pkg::RADIUS_W'(1);
  assign new_sample = flushing ? win[0] : sample;
  assign ctrl.push = push;
  assign ctrl.load = accept && samples_seen == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_left <= '0;
      samples_seen <= '0;
      cnt <= '0;
    end else if (push) begin
      if (flushing) begin
        flush_left <= flush_left - 1'b1;
        cnt <= cnt_next;
      end else if (end_of_line) begin
        flush_left <= r_eff;
        cnt <= {1'b0, seen};
        samples_seen <= '0;
      end else begin
        samples_seen <= seen;
      end
    end
  end

  // Window cells, newest sample in cell zero.
  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    gfce_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .fill_value (new_sample),
      .shift_in   ((i == 0) ? new_sample : win[(i == 0) ? 0 : i - 1]),
      .value      (win[i])
    );
  end

  // Tap units: pair add, then multiply.
  for (genvar d = 0; d <= MAX_RADIUS; d++) begin : g_tap
    always_comb begin
      near_s[d] = '0;
      far_s[d] = '0;
      for (int k = d; k <= MAX_RADIUS; k++) begin
        if (r_eff == gfce_pkg::RADIUS_W'(k)) begin
          near_s[d] = win[k - d];
          far_s[d] = (d == 0) ? '0 : win[k + d];
        end
      end
    end

    gfce_tap #(
      .TAP_W  (TAP_W),
      .PROD_W (PROD_W)
    ) u_tap (
      .clk     (clk),
      .en      (adv),
      .near    (near_s[d]),
      .far     (far_s[d]),
      .tap     (taps[d]),
      .product (prod[d])
    );
  end

  for (genvar k = 0; k < NPART; k++) begin : g_part
    always_ff @(posedge clk) begin
      if (adv) begin
        if (2 * k + 1 <= MAX_RADIUS) begin
          part[k] <= PART_W'(prod[2 * k]) + PART_W'(prod[(2 * k + 1 <= MAX_RADIUS) ? 2 * k + 1 : 0]);
        end else begin
          part[k] <= PART_W'(prod[2 * k]);
        end
      end
    end
  end

  always_comb begin
    total = '0;
    for (int k = 0; k < NPART; k++) begin
      total = total + ACC_W'(part[k]);
    end
  end

  assign scaled = total[ACC_W-1:TAP_FRACTION_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      l0 <= last;
      l1 <= l0;
      l2 <= l1;
      l3 <= l2;
      line_done <= l3;
      smoothed <= (|scaled[SCALED_W-1:8]) ? 8'hFF : scaled[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v0 <= push && emit;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  a_flush_len: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_line |=> flush_left == $past(r_eff))
    else $error("flush length does not match the radius");

  a_seen_clear: assert property (@(posedge clk) disable iff (rst)
    flushing |-> samples_seen == '0)
    else $error("sample count not cleared during flush");

  a_last_end: assert property (@(posedge clk) disable iff (rst)
    v0 && l0 |-> !flushing)
    else $error("last word of a line issued before the flush ended");

endmodule
